// File: rtl/core/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes for the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int IDX_BITS = 9;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_GET    = 2'd1,
        ACT_LOCATE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [4:0]         position;
        logic signed [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [4:0]         found_position;
        logic [4:0]         count_now;
    } rsp_t;

    typedef struct packed {
        logic       insert_en;
        logic [4:0] slot;
    } cell_cmd_t;

endpackage

// File: rtl/core/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell
// One list slot: holds an entry, takes its left neighbor on insert shift,
// and reports a key match and a selected read.
// ----------------------------------------------------------------------------
module sle_cell #(
    parameter int VALUE_BITS = 32,
    parameter int CNT_W      = 5,
    parameter int CELL_INDEX = 0
) (
    input  logic                  clk,
    input  sle_pkg::cell_cmd_t    cmd,
    input  logic [CNT_W-1:0]      count,
    input  logic [VALUE_BITS-1:0] key,
    input  logic [VALUE_BITS-1:0] prev,
    output logic [VALUE_BITS-1:0] value,
    output logic                  hit,
    output logic [VALUE_BITS-1:0] rd
);

    localparam logic [sle_pkg::IDX_BITS-1:0] IDX = sle_pkg::IDX_BITS'(CELL_INDEX);

    logic [VALUE_BITS-1:0]         value_reg;
    logic [sle_pkg::IDX_BITS-1:0]  slot_w;
    logic                          sel;
    logic                          live;

    assign slot_w = sle_pkg::IDX_BITS'(cmd.slot);
    assign sel    = (IDX == slot_w);
    assign live   = (IDX < sle_pkg::IDX_BITS'(count));

    always_ff @(posedge clk)
    begin
        if (cmd.insert_en)
        begin
            if (sel)
                value_reg <= key;
            else if (IDX > slot_w)
                value_reg <= prev;
        end
    end

    assign value = value_reg;
    assign hit   = live && (value_reg == key);
    assign rd    = sel ? value_reg : '0;

endmodule

// File: rtl/core/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// sequential_list_engine
// Bounded ordered list with insert, get and locate, held in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid, req_stall, req) carries one action per
//   transaction: insert at a 1-based position, get at a position, or locate
//   a value. rsp channel (rsp_valid, rsp_stall, rsp) returns exactly one
//   result per request: status, read value, found position and the count
//   after the action.
//   rsp_valid rises in the cycle after acceptance. Throughput is one
//   transaction per cycle unless rsp stalls; every cell shifts and compares
//   in the same cycle, and the result is held in a single output register.
//   While rsp is stalled with a result pending, req_stall is high, so no
//   request is taken until the pending result leaves.
//   Reset empties the list (count zero) and drops any pending result. Entry
//   contents are not cleared; only slots below the count are ever read.
// ----------------------------------------------------------------------------
module sequential_list_engine #(
    parameter int MAX_ENTRIES = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sle_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sle_pkg::rsp_t rsp
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = 10;

    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    sle_pkg::rsp_t          rsp_reg, rsp_next;

    logic                   accept;
    logic [CMP_W-1:0]       pos_w, cnt_w;
    logic                   insert_ok;
    logic [VALUE_BITS-1:0]  key;
    sle_pkg::cell_cmd_t     cmd;

    logic [VALUE_BITS-1:0]  cell_value [MAX_ENTRIES];
    logic [VALUE_BITS-1:0]  cell_rd    [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] hit;
    logic [MAX_ENTRIES-1:0] first_hit;
    logic [VALUE_BITS-1:0]  rd_any;
    logic [sle_pkg::IDX_BITS-1:0] found_idx;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign pos_w = CMP_W'(req.position);
    assign cnt_w = CMP_W'(count_reg);
    assign key   = VALUE_BITS'($unsigned(req.item_value));

    assign insert_ok = (req.action == sle_pkg::ACT_INSERT) && (pos_w != '0) &&
                       (pos_w <= cnt_w + CMP_W'(1)) && (cnt_w < CMP_W'(MAX_ENTRIES));

    assign cmd.insert_en = accept && insert_ok;
    assign cmd.slot      = req.position - 5'd1;

    genvar k;
    generate
        for (k = 0; k < MAX_ENTRIES; k++)
        begin : g_cell
            logic [VALUE_BITS-1:0] prev;
            if (k == 0)
            begin : g_head
                assign prev = key;
            end
            else
            begin : g_body
                assign prev = cell_value[k-1];
            end

            sle_cell #(
                .VALUE_BITS (VALUE_BITS),
                .CNT_W      (CNT_W),
                .CELL_INDEX (k)
            ) u_cell (
                .clk   (clk),
                .cmd   (cmd),
                .count (count_reg),
                .key   (key),
                .prev  (prev),
                .value (cell_value[k]),
                .hit   (hit[k]),
                .rd    (cell_rd[k])
            );
        end
    endgenerate

    assign first_hit = hit & (~hit + MAX_ENTRIES'(1));

    always_comb
    begin
        rd_any    = '0;
        found_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            rd_any = rd_any | cell_rd[i];
            if (first_hit[i])
                found_idx = found_idx | sle_pkg::IDX_BITS'(i + 1);
        end
    end

    always_comb
    begin
        count_next            = count_reg;
        rsp_next              = rsp_reg;
        rsp_valid_next        = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.status        = sle_pkg::ST_DONE;
            rsp_next.read_value    = '0;
            rsp_next.found_position = '0;
            case (req.action)
                sle_pkg::ACT_INSERT:
                begin
                    if ((pos_w == '0) || (pos_w > cnt_w + CMP_W'(1)))
                        rsp_next.status = sle_pkg::ST_RANGE;
                    else if (cnt_w >= CMP_W'(MAX_ENTRIES))
                        rsp_next.status = sle_pkg::ST_FULL;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                sle_pkg::ACT_GET:
                begin
                    if ((pos_w == '0) || (pos_w > cnt_w))
                        rsp_next.status = sle_pkg::ST_RANGE;
                    else
                        rsp_next.read_value = $signed(32'(rd_any));
                end
                sle_pkg::ACT_LOCATE:
                begin
                    rsp_next.found_position = found_idx[4:0];
                end
                default:
                begin
                    rsp_next.status = sle_pkg::ST_RANGE;
                end
            endcase
            rsp_next.count_now = 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(MAX_ENTRIES))
        else $error("list count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && insert_ok) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted insert did not grow the list");

    a_count_report: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.count_now == 5'(count_reg)))
        else $error("reported count differs from list count");

    a_hold_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> (count_reg == $past(count_reg)))
        else $error("list count changed without a transaction");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sequential list engine. A directed table first
// covers the empty list, the value extremes, every action, the unused action
// code, refused inserts and a list filled to capacity. A random mix of gets,
// locates, refused inserts and unused action codes on the full list follows.
// Both channels idle at random. Every result is checked field by field, against
// a directed row's fixed result if it has one, else a bench model of the list.
// ----------------------------------------------------------------------------
module tb;

    localparam int            LIST_DEPTH   = 16;
    localparam int            IDX_W        = $clog2(LIST_DEPTH);
    localparam int            RANDOM_ITEMS = 1600;
    localparam int            CYCLE_LIMIT  = 400000;
    localparam logic [1:0]    ACT_UNUSED   = 2'd3;
    localparam sle_pkg::rsp_t NO_FIXED_RSP = '0;

    typedef struct packed {
        sle_pkg::req_t rq;
        logic [4:0]    reps;
        logic          fixed;
        sle_pkg::rsp_t want;
    } script_row_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    localparam int SCRIPT_ROWS = 28;
    localparam script_row_t DIRECTED_SCRIPT [SCRIPT_ROWS] = '{
        '{'{sle_pkg::ACT_GET,    5'd1,  32'sd0},        5'd1, 1'b1,
            '{sle_pkg::ST_RANGE, 32'sd0, 5'd0, 5'd0}},
        '{'{sle_pkg::ACT_GET,    5'd0,  32'sd0},        5'd1, 1'b1,
            '{sle_pkg::ST_RANGE, 32'sd0, 5'd0, 5'd0}},
        '{'{sle_pkg::ACT_LOCATE, 5'd0,  32'sd0},        5'd1, 1'b1,
            '{sle_pkg::ST_DONE,  32'sd0, 5'd0, 5'd0}},
        '{'{sle_pkg::ACT_INSERT, 5'd0,  32'sd7},        5'd1, 1'b1,
            '{sle_pkg::ST_RANGE, 32'sd0, 5'd0, 5'd0}},
        '{'{sle_pkg::ACT_INSERT, 5'd2,  32'sd7},        5'd1, 1'b1,
            '{sle_pkg::ST_RANGE, 32'sd0, 5'd0, 5'd0}},
        '{'{ACT_UNUSED,          5'd31, 32'shFFFFFFFF}, 5'd1, 1'b1,
            '{sle_pkg::ST_RANGE, 32'sd0, 5'd0, 5'd0}},
        '{'{sle_pkg::ACT_INSERT, 5'd1,  32'sh7FFFFFFF}, 5'd1, 1'b1,
            '{sle_pkg::ST_DONE,  32'sd0, 5'd0, 5'd1}},
        '{'{sle_pkg::ACT_INSERT, 5'd1,  32'sh80000000}, 5'd1, 1'b1,
            '{sle_pkg::ST_DONE,  32'sd0, 5'd0, 5'd2}},
        '{'{sle_pkg::ACT_GET,    5'd1,  32'sd0},        5'd1, 1'b1,
            '{sle_pkg::ST_DONE,  32'sh80000000, 5'd0, 5'd2}},
        '{'{sle_pkg::ACT_GET,    5'd2,  32'sd0},        5'd1, 1'b1,
            '{sle_pkg::ST_DONE,  32'sh7FFFFFFF, 5'd0, 5'd2}},
        '{'{sle_pkg::ACT_GET,    5'd3,  32'sd0},        5'd1, 1'b1,
            '{sle_pkg::ST_RANGE, 32'sd0, 5'd0, 5'd2}},
        '{'{sle_pkg::ACT_INSERT, 5'd3,  32'shFFFFFFFF}, 5'd1, 1'b1,
            '{sle_pkg::ST_DONE,  32'sd0, 5'd0, 5'd3}},
        '{'{sle_pkg::ACT_LOCATE, 5'd0,  32'shFFFFFFFF}, 5'd1, 1'b1,
            '{sle_pkg::ST_DONE,  32'sd0, 5'd3, 5'd3}},
        '{'{sle_pkg::ACT_LOCATE, 5'd31, 32'sh80000000}, 5'd1, 1'b1,
            '{sle_pkg::ST_DONE,  32'sd0, 5'd1, 5'd3}},
        '{'{sle_pkg::ACT_LOCATE, 5'd0,  32'sh7FFFFFFE}, 5'd1, 1'b1,
            '{sle_pkg::ST_DONE,  32'sd0, 5'd0, 5'd3}},
        '{'{sle_pkg::ACT_INSERT, 5'd2,  32'sd100},      5'd6, 1'b0, NO_FIXED_RSP},
        '{'{sle_pkg::ACT_INSERT, 5'd5,  32'sd200},      5'd6, 1'b0, NO_FIXED_RSP},
        '{'{sle_pkg::ACT_LOCATE, 5'd0,  32'sh7FFFFFFF}, 5'd1, 1'b0, NO_FIXED_RSP},
        '{'{sle_pkg::ACT_INSERT, 5'd16, 32'sd0},        5'd1, 1'b1,
            '{sle_pkg::ST_DONE,  32'sd0, 5'd0, 5'd16}},
        '{'{sle_pkg::ACT_INSERT, 5'd17, 32'sd1},        5'd1, 1'b1,
            '{sle_pkg::ST_FULL,  32'sd0, 5'd0, 5'd16}},
        '{'{sle_pkg::ACT_INSERT, 5'd1,  32'sd5},        5'd1, 1'b1,
            '{sle_pkg::ST_FULL,  32'sd0, 5'd0, 5'd16}},
        '{'{sle_pkg::ACT_INSERT, 5'd18, 32'sd1},        5'd1, 1'b1,
            '{sle_pkg::ST_RANGE, 32'sd0, 5'd0, 5'd16}},
        '{'{sle_pkg::ACT_INSERT, 5'd31, 32'sd1},        5'd1, 1'b1,
            '{sle_pkg::ST_RANGE, 32'sd0, 5'd0, 5'd16}},
        '{'{sle_pkg::ACT_GET,    5'd16, 32'sd0},        5'd1, 1'b0, NO_FIXED_RSP},
        '{'{sle_pkg::ACT_GET,    5'd17, 32'sd0},        5'd1, 1'b1,
            '{sle_pkg::ST_RANGE, 32'sd0, 5'd0, 5'd16}},
        '{'{sle_pkg::ACT_GET,    5'd31, 32'sd0},        5'd1, 1'b1,
            '{sle_pkg::ST_RANGE, 32'sd0, 5'd0, 5'd16}},
        '{'{sle_pkg::ACT_LOCATE, 5'd0,  32'sd0},        5'd1, 1'b0, NO_FIXED_RSP},
        '{'{ACT_UNUSED,          5'd0,  32'sd0},        5'd1, 1'b1,
            '{sle_pkg::ST_RANGE, 32'sd0, 5'd0, 5'd16}}
    };

    logic          clk = 1'b0;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    sle_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    sle_pkg::rsp_t rsp;

    logic signed [31:0] list_vals [LIST_DEPTH];
    int                 list_len = 0;
    sle_pkg::rsp_t      pending_results [$];
    sle_pkg::rsp_t      oldest_result;

    int          sent_count      = 0;
    int          checked_count   = 0;
    int          fail_count      = 0;
    int          inserts_stored  = 0;
    int          inserts_full    = 0;
    int          range_refusals  = 0;
    int          locate_hits     = 0;
    int          cycle_count     = 0;
    int          burst_left      = 20;
    int          stall_left      = 0;
    int          stall_tick      = 0;
    stall_mode_t stall_mode      = STALL_NONE;

    sequential_list_engine #(
        .MAX_ENTRIES(LIST_DEPTH),
        .VALUE_BITS (32)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Applies one action to the bench copy of the list and returns its result.
    function automatic sle_pkg::rsp_t apply_list_action(input sle_pkg::req_t rq);
        sle_pkg::rsp_t o;
        int            pos;
        int            k;
        o   = '0;
        pos = int'(rq.position);
        o.status = sle_pkg::ST_DONE;
        case (rq.action)
            sle_pkg::ACT_INSERT:
            begin
                if (pos < 1 || pos > list_len + 1)
                    o.status = sle_pkg::ST_RANGE;
                else if (list_len >= LIST_DEPTH)
                    o.status = sle_pkg::ST_FULL;
                else
                begin
                    for (k = list_len; k >= pos; k--)
                        list_vals[IDX_W'(k)] = list_vals[IDX_W'(k - 1)];
                    list_vals[IDX_W'(pos - 1)] = rq.item_value;
                    list_len++;
                end
            end
            sle_pkg::ACT_GET:
            begin
                if (pos < 1 || pos > list_len)
                    o.status = sle_pkg::ST_RANGE;
                else
                    o.read_value = list_vals[IDX_W'(pos - 1)];
            end
            sle_pkg::ACT_LOCATE:
            begin
                for (k = 0; k < list_len; k++)
                begin
                    if (list_vals[IDX_W'(k)] == rq.item_value)
                    begin
                        o.found_position = 5'(k + 1);
                        break;
                    end
                end
            end
            default:
                o.status = sle_pkg::ST_RANGE;
        endcase
        o.count_now = 5'(list_len);
        return o;
    endfunction

    // Called at a falling edge; returns at a falling edge after acceptance.
    task automatic send_request(input sle_pkg::req_t rq, input logic use_fixed,
                                input sle_pkg::rsp_t fixed_rsp);
        sle_pkg::rsp_t predicted;
        req_valid <= 1'b1;
        req       <= rq;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = apply_list_action(rq);
        pending_results.push_back(use_fixed ? fixed_rsp : predicted);
        sent_count++;
        if (predicted.status == sle_pkg::ST_RANGE)
            range_refusals++;
        else if (predicted.status == sle_pkg::ST_FULL)
            inserts_full++;
        else if (rq.action == sle_pkg::ACT_INSERT)
            inserts_stored++;
        if (predicted.found_position != 5'd0)
            locate_hits++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(0, 30);
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 300);
        end
        else
            stall_left <= stall_left - 1;
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
            default:     rsp_stall <= (stall_tick % 8 < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected: %p", $time, rsp);
                fail_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                checked_count++;
                if (rsp.status !== oldest_result.status)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $time, oldest_result.status, rsp.status);
                    fail_count++;
                end
                if (rsp.read_value !== oldest_result.read_value)
                begin
                    $display("%0t: read_value expected %0d got %0d",
                             $time, oldest_result.read_value, rsp.read_value);
                    fail_count++;
                end
                if (rsp.found_position !== oldest_result.found_position)
                begin
                    $display("%0t: found_position expected %0d got %0d",
                             $time, oldest_result.found_position, rsp.found_position);
                    fail_count++;
                end
                if (rsp.count_now !== oldest_result.count_now)
                begin
                    $display("%0t: count_now expected %0d got %0d",
                             $time, oldest_result.count_now, rsp.count_now);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("%0t: no finish within %0d cycles, %0d results outstanding",
                 $time, CYCLE_LIMIT, pending_results.size());
        $display("sequential_list_engine: mismatch");
        $finish;
    end

    initial
    begin
        sle_pkg::req_t rq;
        int            row;
        int            rep;
        int            n;
        int            sel;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_stall = 1'b0;
        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (row = 0; row < SCRIPT_ROWS; row++)
        begin
            for (rep = 0; rep < int'(DIRECTED_SCRIPT[row].reps); rep++)
            begin
                rq            = DIRECTED_SCRIPT[row].rq;
                rq.item_value = rq.item_value + 32'(rep);
                send_request(rq, DIRECTED_SCRIPT[row].fixed, DIRECTED_SCRIPT[row].want);
            end
        end

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel           = $urandom_range(0, 99);
            rq.item_value = $urandom;
            rq.position   = 5'($urandom_range(0, 31));
            if (sel < 35)
            begin
                rq.action = sle_pkg::ACT_GET;
                if ($urandom_range(0, 4) != 0 && list_len > 0)
                    rq.position = 5'($urandom_range(1, list_len));
            end
            else if (sel < 70)
            begin
                rq.action = sle_pkg::ACT_LOCATE;
                if ($urandom_range(0, 9) < 6 && list_len > 0)
                    rq.item_value = list_vals[IDX_W'($urandom_range(0, list_len - 1))];
            end
            else if (sel < 90)
            begin
                rq.action = sle_pkg::ACT_INSERT;
                if ($urandom_range(0, 2) == 0)
                    rq.position = 5'($urandom_range(1, list_len + 1));
            end
            else
                rq.action = ACT_UNUSED;
            send_request(rq, 1'b0, NO_FIXED_RSP);
        end
        req_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);

        $display("Sent %0d requests: %0d inserts stored, %0d refused as full, %0d out of range.",
                 sent_count, inserts_stored, inserts_full, range_refusals);
        $display("Checked %0d results, %0d locates found a match, %0d failures.",
                 checked_count, locate_hits, fail_count);
        if (fail_count == 0)
            $display("sequential_list_engine: match");
        else
            $display("sequential_list_engine: mismatch");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sle_pkg.sv
rtl/core/sle_cell.sv
rtl/core/sequential_list_engine.sv
tb/tb.sv
